// ----- sv/bed_pkg.sv -----
// Shared types and constants for the backslash escape decoder.
// No dependencies; imported by every module of the block.
package bed_pkg;

    localparam int COUNT_BITS = 16;     // width of the saturating byte counter
    localparam int Q_DEPTH    = 4;      // entries in the front-to-back queue
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam int S_DATA_W   = 8;      // in_byte
    localparam int M_DATA_W   = 24;     // out_byte, total_count
    localparam int M_USER_W   = 3;      // byte_valid, fail, finished

    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_MAX  = 8'hff;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_USCR = 8'h5f;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_ESC  = 3'd1,
        M_CTRL = 3'd2,
        M_HEX0 = 3'd3,
        M_HEX1 = 3'd4,
        M_OCT1 = 3'd5,
        M_OCT2 = 3'd6,
        M_DROP = 3'd7
    } mode_t;

    // One classified input item: one or two results to be given.
    typedef struct packed {
        logic       two;    // a second result follows the first
        logic       done0;  // first result is the done result
        logic       done1;  // second result is the done result
        logic       fail;   // fail flag shown in a done result
        logic [7:0] byte0;
        logic [7:0] byte1;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- sv/bed_front.sv -----
// Front part: escape state machine that classifies each accepted byte.
// Depends on bed_pkg; pushes result records into bed_queue.
module bed_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 in_byte,
    input  logic                       end_mark,
    input  bed_pkg::q_stat_t           q_stat,
    output logic                       push,
    output bed_pkg::rec_t              rec
);
    import bed_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] digit_reg, digit_next;
    logic       has_res;
    logic       accept;
    logic [4:0] hex_v;
    logic       is_oct;
    logic [7:0] ctl_u;
    logic [10:0] oct_v;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // hold off the sender while in reset
    assign s_tready = aresetn && !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && has_res;

    assign hex_v  = hex_val(in_byte);
    assign is_oct = (in_byte[7:3] == 5'b00110);
    assign ctl_u  = (in_byte >= 8'h61 && in_byte <= 8'h7a) ? in_byte - 8'h20 : in_byte;
    assign oct_v  = {digit_reg, in_byte[2:0]};

    always_comb begin
        mode_next  = mode_reg;
        digit_next = digit_reg;
        has_res    = 1'b0;
        rec        = '0;
        if (end_mark) begin
            // flush the pending escape, then the done result
            has_res    = 1'b1;
            mode_next  = M_IDLE;
            digit_next = 8'd0;
            unique case (mode_reg)
                M_ESC: begin
                    rec.two   = 1'b1;
                    rec.byte0 = CH_BSL;
                    rec.done1 = 1'b1;
                end
                M_HEX1, M_OCT1, M_OCT2: begin
                    rec.two   = 1'b1;
                    rec.byte0 = digit_reg;
                    rec.done1 = 1'b1;
                end
                M_CTRL, M_HEX0: begin
                    rec.done0 = 1'b1;
                    rec.fail  = 1'b1;
                end
                M_DROP: begin
                    rec.done0 = 1'b1;
                    rec.fail  = 1'b1;
                end
                default: begin
                    rec.done0 = 1'b1;
                end
            endcase
        end else begin
            unique case (mode_reg)
                M_IDLE: begin
                    if (in_byte == CH_BSL) begin
                        mode_next = M_ESC;
                    end else begin
                        has_res   = 1'b1;
                        rec.byte0 = in_byte;
                    end
                end
                M_ESC: begin
                    mode_next = M_IDLE;
                    has_res   = 1'b1;
                    rec.byte0 = in_byte;
                    unique case (in_byte)
                        8'h61: rec.byte0 = 8'h07;      // a
                        8'h62: rec.byte0 = 8'h08;      // b
                        8'h65, 8'h45: rec.byte0 = CH_ESC;
                        8'h66: rec.byte0 = 8'h0c;      // f
                        8'h6e: rec.byte0 = 8'h0a;      // n
                        8'h72: rec.byte0 = 8'h0d;      // r
                        8'h74: rec.byte0 = 8'h09;      // t
                        8'h76: rec.byte0 = 8'h0b;      // v
                        8'h63: begin                   // c
                            has_res   = 1'b0;
                            mode_next = M_CTRL;
                        end
                        8'h78: begin                   // x
                            has_res   = 1'b0;
                            mode_next = M_HEX0;
                        end
                        default: begin
                            if (is_oct) begin
                                has_res    = 1'b0;
                                digit_next = {5'd0, in_byte[2:0]};
                                mode_next  = M_OCT1;
                            end
                        end
                    endcase
                end
                M_CTRL: begin
                    if (ctl_u >= CH_A && ctl_u <= CH_USCR) begin
                        has_res   = 1'b1;
                        rec.byte0 = ctl_u - 8'h40;
                        mode_next = M_IDLE;
                    end else begin
                        mode_next = M_DROP;
                    end
                end
                M_HEX0: begin
                    if (hex_v[4]) begin
                        digit_next = {4'd0, hex_v[3:0]};
                        mode_next  = M_HEX1;
                    end else begin
                        mode_next = M_DROP;
                    end
                end
                M_DROP: begin
                    mode_next = M_DROP;
                end
                default: begin
                    // M_HEX1, M_OCT1, M_OCT2: digit or close of the escape
                    has_res   = 1'b1;
                    mode_next = M_IDLE;
                    if (mode_reg == M_HEX1 && hex_v[4]) begin
                        rec.byte0 = {digit_reg[3:0], hex_v[3:0]};
                    end else if (mode_reg == M_OCT1 && is_oct) begin
                        has_res    = 1'b0;
                        digit_next = oct_v[7:0];
                        mode_next  = M_OCT2;
                    end else if (mode_reg == M_OCT2 && is_oct && oct_v <= {3'd0, CH_MAX}) begin
                        rec.byte0 = oct_v[7:0];
                    end else begin
                        // give the gathered value, then treat this byte as plain
                        rec.byte0 = digit_reg;
                        if (in_byte == CH_BSL) begin
                            mode_next = M_ESC;
                        end else begin
                            rec.two   = 1'b1;
                            rec.byte1 = in_byte;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            digit_reg <= 8'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ----- sv/bed_queue.sv -----
// Short record queue between the front and back parts.
// Depends on bed_pkg for the record type and depth.
module bed_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bed_pkg::rec_t       wr_rec,
    input  logic                pop,
    output bed_pkg::rec_t       rd_rec,
    output bed_pkg::q_stat_t    q_stat
);
    import bed_pkg::*;

    rec_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push, do_pop;

    assign q_stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign rd_rec       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

endmodule

// ----- sv/bed_back.sv -----
// Back part: expands records into result transfers and keeps the byte count.
// Depends on bed_pkg; pops records from bed_queue.
module bed_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bed_pkg::rec_t                  q_rec,
    input  bed_pkg::q_stat_t               q_stat,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bed_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [bed_pkg::M_USER_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import bed_pkg::*;

    logic                  valid_reg;
    logic [M_DATA_W-1:0]   data_reg;
    logic [M_USER_W-1:0]   user_reg;
    logic                  last_reg;
    logic                  sec_reg;
    logic                  sec_done_reg;
    logic                  sec_fail_reg;
    logic [7:0]            sec_byte_reg;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_inc;
    logic                  load;
    logic                  sel_done, sel_fail, sel_last;
    logic [7:0]            sel_byte;

    function automatic logic [15:0] shown(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000_ffff) ? 16'hffff : w[15:0];
    endfunction

    assign load    = !valid_reg || m_tready;
    assign pop     = load && !sec_reg && !q_stat.empty;
    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    always_comb begin
        if (sec_reg) begin
            sel_done = sec_done_reg;
            sel_fail = sec_fail_reg;
            sel_byte = sec_byte_reg;
            sel_last = 1'b1;
        end else begin
            sel_done = q_rec.done0;
            sel_fail = q_rec.fail;
            sel_byte = q_rec.byte0;
            sel_last = !q_rec.two;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            last_reg <= sel_last;
            if (sel_done) begin
                data_reg <= {shown(cnt_reg), 8'd0};
                user_reg <= {1'b1, sel_fail, 1'b0};
            end else begin
                data_reg <= {shown(cnt_inc), sel_byte};
                user_reg <= {1'b0, 1'b0, 1'b1};
            end
        end
        if (pop) begin
            sec_done_reg <= q_rec.done1;
            sec_fail_reg <= q_rec.fail;
            sec_byte_reg <= q_rec.byte1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else if (load) begin
            if (sec_reg || !q_stat.empty) begin
                valid_reg <= 1'b1;
                cnt_reg   <= sel_done ? '0 : cnt_inc;
                sec_reg   <= sec_reg ? 1'b0 : q_rec.two;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- sv/backslash_escape_decoder.sv -----
// Top level of the backslash escape decoder: front, queue and back parts.
// Depends on bed_pkg, bed_front, bed_queue and bed_back.
//
//   channel | dir | tdata               | tuser                       | tlast
//   s_      | in  | [7:0] in_byte       | -                           | end_mark
//   m_      | out | [7:0] out_byte,     | [0] byte_valid, [1] fail,   | run_last
//           |     | [23:8] total_count  | [2] finished                |
//
// One input transfer per cycle while the record queue has room. Each item
// is classified in the cycle it is accepted and reaches m_ through the
// record queue and the output register; an item that yields two results
// holds the output for both, and the four-entry record queue absorbs this so input
// keeps flowing. Reset is synchronous on aresetn low; no clearing pass.
// A stalled m_ side fills the queue, then drops s_tready; neither side
// depends combinationally on the other's handshake.
module backslash_escape_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bed_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,   // end_mark
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bed_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] out_byte, [23:8] total_count
    output logic [bed_pkg::M_USER_W-1:0]  m_tuser,   // [0] byte_valid, [1] fail, [2] finished
    output logic                          m_tlast    // run_last
);
    import bed_pkg::*;

    rec_t    wr_rec, rd_rec;
    q_stat_t q_stat;
    logic    push, pop;

    // Classify each byte against the escape state
    bed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_byte  (s_tdata[7:0]),
        .end_mark (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .rec      (wr_rec)
    );

    // Hold records between the two halves
    bed_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_rec  (wr_rec),
        .pop     (pop),
        .rd_rec  (rd_rec),
        .q_stat  (q_stat)
    );

    // Expand records into transfers, count decoded bytes
    bed_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rec    (rd_rec),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sv/bed_checker.sv -----
// Port-level checks for the backslash escape decoder, bound to the top level.
// Depends on bed_pkg for the port widths.
module bed_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bed_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [bed_pkg::M_USER_W-1:0]  m_tuser,
    input logic                          m_tlast
);
    import bed_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // the done result carries no byte and closes its item
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0] && m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("malformed done result");

    // a decoded byte never shows the fail or finished flag
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[2])
        else $error("byte result with fail or finished set");

    // the second result of an item follows straight after the first
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("second result of an item missing");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/backslash_escape_decoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the backslash escape decoder: drives strings of escaped text,
// predicts every decoded byte and done transfer, and checks them in order.
// Depends on bed_pkg and backslash_escape_decoder.

module backslash_escape_decoder_tb;
    import bed_pkg::*;

    typedef logic [7:0] text_t[$];

    // One expected transfer on the m_ channel, unpacked into its fields.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        fail;
        logic        finished;
        logic [15:0] total_count;
        logic        run_last;
    } decoded_t;

    // Escape decoding predictor plus the queue of transfers it still awaits.
    class escape_scoreboard;
        localparam longint unsigned TOTAL_MAX = (64'd1 << COUNT_BITS) - 64'd1;
        localparam int MAX_REPORTS = 200;

        mode_t            mode;
        logic [7:0]       digits;
        longint unsigned  byte_total;
        logic             fail_flag;
        decoded_t         caused[$];
        decoded_t         awaited[$];
        int               errors;

        function new();
            clear_string();
            errors = 0;
        endfunction

        function void clear_string();
            mode       = M_IDLE;
            digits     = 8'h00;
            byte_total = 0;
            fail_flag  = 1'b0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void give(logic [7:0] b, logic valid, logic done);
            decoded_t r;
            r.out_byte    = b;
            r.byte_valid  = valid;
            r.fail        = fail_flag;
            r.finished    = done;
            r.total_count = (byte_total > 64'hffff) ? 16'hffff : byte_total[15:0];
            r.run_last    = 1'b0;
            caused.push_back(r);
        endfunction

        function void emit_byte(logic [7:0] b);
            if (byte_total < TOTAL_MAX)
                byte_total++;
            give(b, 1'b1, 1'b0);
        endfunction

        function void start_drop();
            fail_flag = 1'b1;
            digits    = 8'h00;
            mode      = M_DROP;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function bit is_octal(logic [7:0] c);
            return (c >= "0" && c <= "7");
        endfunction

        function void plain_byte(logic [7:0] c);
            mode   = M_IDLE;
            digits = 8'h00;
            if (c == CH_BSL)
                mode = M_ESC;
            else
                emit_byte(c);
        endfunction

        function void escaped_byte(logic [7:0] c);
            mode = M_IDLE;
            case (c)
                CH_BSL:   emit_byte(CH_BSL);
                "a":      emit_byte(8'h07);
                "b":      emit_byte(8'h08);
                "e", "E": emit_byte(CH_ESC);
                "f":      emit_byte(8'h0c);
                "n":      emit_byte(8'h0a);
                "r":      emit_byte(8'h0d);
                "t":      emit_byte(8'h09);
                "v":      emit_byte(8'h0b);
                "c":      mode = M_CTRL;
                "x":      mode = M_HEX0;
                default: begin
                    if (is_octal(c)) begin
                        digits = {5'd0, c[2:0]};
                        mode   = M_OCT1;
                    end else begin
                        emit_byte(c);
                    end
                end
            endcase
        endfunction

        function void take_byte(logic [7:0] c);
            int          h;
            logic [7:0]  u;
            logic [10:0] v;
            h = hex_digit(c);
            case (mode)
                M_IDLE: plain_byte(c);
                M_ESC:  escaped_byte(c);
                M_CTRL: begin
                    u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
                    if (u >= CH_A && u <= CH_USCR) begin
                        emit_byte(u - CH_A + 8'd1);
                        mode = M_IDLE;
                    end else begin
                        start_drop();
                    end
                end
                M_HEX0: begin
                    if (h >= 0) begin
                        digits = h[7:0];
                        mode   = M_HEX1;
                    end else begin
                        start_drop();
                    end
                end
                M_HEX1: begin
                    if (h >= 0) begin
                        emit_byte({digits[3:0], h[3:0]});
                        mode   = M_IDLE;
                        digits = 8'h00;
                    end else begin
                        emit_byte(digits);
                        plain_byte(c);
                    end
                end
                M_OCT1: begin
                    if (is_octal(c)) begin
                        digits = {digits[4:0], c[2:0]};
                        mode   = M_OCT2;
                    end else begin
                        emit_byte(digits);
                        plain_byte(c);
                    end
                end
                M_OCT2: begin
                    v = {digits, c[2:0]};
                    if (is_octal(c) && v <= 11'(CH_MAX)) begin
                        emit_byte(v[7:0]);
                        mode   = M_IDLE;
                        digits = 8'h00;
                    end else begin
                        // overflowing third digit or a non-digit: give two digits, reread c
                        emit_byte(digits);
                        plain_byte(c);
                    end
                end
                default: ;
            endcase
        endfunction

        function void end_string();
            case (mode)
                M_ESC:                  emit_byte(CH_BSL);
                M_CTRL, M_HEX0:         fail_flag = 1'b1;
                M_HEX1, M_OCT1, M_OCT2: emit_byte(digits);
                default: ;
            endcase
            give(8'h00, 1'b0, 1'b1);
            clear_string();
        endfunction

        // Predict the transfers caused by one accepted input and queue them.
        function void note_input(logic [7:0] c, logic end_mark);
            caused.delete();
            if (end_mark)
                end_string();
            else
                take_byte(c);
            if (caused.size() > 0)
                caused[caused.size() - 1].run_last = 1'b1;
            foreach (caused[i])
                awaited.push_back(caused[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] tdata, logic [M_USER_W-1:0] tuser,
                                   logic tlast);
            decoded_t want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result with no expectation waiting: tdata 0x%0h tuser 0x%0h",
                           tdata, tuser);
                return;
            end
            want = awaited.pop_front();
            compare_field("out_byte",    32'(want.out_byte),    32'(tdata[7:0]));
            compare_field("total_count", 32'(want.total_count), 32'(tdata[23:8]));
            compare_field("byte_valid",  32'(want.byte_valid),  32'(tuser[0]));
            compare_field("fail",        32'(want.fail),        32'(tuser[1]));
            compare_field("finished",    32'(want.finished),    32'(tuser[2]));
            compare_field("run_last",    32'(want.run_last),    32'(tlast));
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer before giving up
    localparam int SETTLE       = 20;     // cycles to wait once nothing is awaited

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_MOSTLY,
        RDY_PERIODIC,
        RDY_SPARSE
    } ready_style_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 m_tlast;

    escape_scoreboard sb;
    int               burst_left;
    int               items_sent;
    int               hold_requests;
    int               holds_served;
    int               idle_cycles;

    backslash_escape_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // After each transfer, count down the burst; when it runs out, drop
    // tvalid for a random gap and pick the next burst length. Now and then
    // a long burst gives a stretch with no idling at all.
    task automatic pace_sender();
        int unsigned gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Offer one item and hold it until the transfer happens; tvalid stays
    // high into the next item unless the pacing drops it.
    task automatic push_item(input logic [7:0] b, input logic end_mark);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= end_mark;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, end_mark);
        items_sent++;
        pace_sender();
    endtask

    task automatic send_text(input text_t text, input logic [7:0] end_byte);
        foreach (text[i])
            push_item(text[i], 1'b0);
        push_item(end_byte, 1'b1);
    endtask

    // Stop offering and wait until every awaited transfer has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] any_hex_digit();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'("0") + 8'(k);
        if (k < 16) return 8'("a") + 8'(k - 10);
        return 8'("A") + 8'(k - 16);
    endfunction

    function automatic logic [7:0] simple_letter();
        case ($urandom_range(0, 9))
            0: return CH_BSL;
            1: return "a";
            2: return "b";
            3: return "f";
            4: return "n";
            5: return "r";
            6: return "t";
            7: return "v";
            8: return "e";
            default: return "E";
        endcase
    endfunction

    // Append one well-formed token (or, rarely, a malformed escape).
    function automatic void add_token(ref text_t t);
        int unsigned sel;
        int unsigned n;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            t.push_back(8'($urandom));
        end else if (sel < 42) begin
            t.push_back(CH_BSL);
            t.push_back(simple_letter());
        end else if (sel < 54) begin
            t.push_back(CH_BSL);
            t.push_back("c");
            case ($urandom_range(0, 4))
                0:       t.push_back(8'($urandom));
                1:       t.push_back(8'($urandom_range(8'h61, 8'h7a)));
                default: t.push_back(8'($urandom_range(CH_A, CH_USCR)));
            endcase
        end else if (sel < 68) begin
            t.push_back(CH_BSL);
            t.push_back("x");
            t.push_back(any_hex_digit());
            if ($urandom_range(0, 9) < 6)
                t.push_back(any_hex_digit());
        end else if (sel < 84) begin
            t.push_back(CH_BSL);
            n = $urandom_range(1, 3);
            repeat (n) t.push_back(8'("0") + 8'($urandom_range(0, 7)));
        end else if (sel < 92) begin
            t.push_back(CH_BSL);
            t.push_back(8'($urandom));
        end else begin
            // x followed by anything, mostly a non-hex byte: bare x
            t.push_back(CH_BSL);
            t.push_back("x");
            t.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'("g"));
        end
    endfunction

    function automatic text_t random_text();
        text_t       t;
        int unsigned n;
        int unsigned tail;
        if ($urandom_range(0, 9) == 0) begin
            // noise: raw bytes, backslashes included by chance
            n = $urandom_range(0, 10);
            repeat (n) t.push_back(8'($urandom));
        end else begin
            n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
            repeat (n) add_token(t);
            tail = $urandom_range(0, 19);
            if (tail < 2) begin
                t.push_back(CH_BSL);                 // trailing backslash
            end else if (tail == 2) begin
                t.push_back(CH_BSL);                 // c left open at the end
                t.push_back("c");
            end else if (tail == 3) begin
                t.push_back(CH_BSL);                 // x left open at the end
                t.push_back("x");
            end
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: a ready style of its own that changes every so often,
    // with a long hold-off whenever the stimulus asks for one.
    // ------------------------------------------------------------------
    initial begin : receiver
        ready_style_t style;
        int unsigned  style_left;
        int unsigned  tick;
        m_tready   <= 1'b0;
        style       = RDY_ALWAYS;
        style_left  = 0;
        tick        = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                if (style_left == 0) begin
                    style      = ready_style_t'($urandom_range(RDY_ALWAYS, RDY_SPARSE));
                    style_left = $urandom_range(32, 256);
                end
                style_left--;
                tick++;
                case (style)
                    RDY_ALWAYS:   m_tready <= 1'b1;
                    RDY_HALF:     m_tready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY:   m_tready <= ($urandom_range(0, 9) != 0);
                    RDY_PERIODIC: m_tready <= (tick % 4 != 0);
                    default:      m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("backslash_escape_decoder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        text_t      t;
        bit         held;
        bit         drained;

        sb            = new();
        burst_left    = 1;
        items_sent    = 0;
        hold_requests = 0;
        held          = 1'b0;
        drained       = 1'b0;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: byte extremes, a doubled backslash, a C letter escape,
        // a lower-case control escape, an octal escape that overflows
        // (gives two bytes), and hex digits still open at the end marker.
        t = '{8'h00, 8'hff, CH_BSL, CH_BSL, CH_BSL, "n", CH_BSL, "c", "a",
              CH_BSL, "4", "0", "0", CH_BSL, "x", "f"};
        send_text(t, 8'ha5);
        // trailing backslash
        t = '{CH_BSL};
        send_text(t, 8'h5a);
        // bare x: error, then the rest of the string is dropped
        t = '{"q", CH_BSL, "x", "g", "z"};
        send_text(t, 8'hff);

        // Random strings, mostly well formed
        while (items_sent < RANDOM_ITEMS) begin
            send_text(random_text(), 8'($urandom));
            if (!held && items_sent > 400) begin
                // hold the receiver off while input keeps coming: fill the block
                held = 1'b1;
                hold_requests++;
            end
            if (!drained && items_sent > 900) begin
                drained = 1'b1;
                drain();
            end
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("backslash_escape_decoder verification clean");
        end else begin
            $display("backslash_escape_decoder verification failed");
        end
        $finish;
    end

endmodule
